### sv/tvnh_pkg.sv
// Package for the tiling value-noise heightmap generator.
// Holds Q1.16 constants, octave weights and hash constants; no dependencies.
package tvnh_pkg;

    localparam int TILE_SIZE_DEF = 256;
    localparam int NUM_OCT       = 5;
    localparam int Q             = 16;
    localparam logic [17:0] ONE_Q16 = 18'd65536;

    localparam logic [31:0] HASH_X    = 32'd374761393;
    localparam logic [31:0] HASH_Y    = 32'd668265263;
    localparam logic [31:0] HASH_S    = 32'd2246822519;
    localparam logic [31:0] HASH_MIX  = 32'd1274126177;
    localparam logic [31:0] SEED_MULT = 32'd2654435761;

    localparam logic [15:0] W_CONT  = 16'd39322;
    localparam logic [15:0] W_DET   = 16'd26214;
    localparam logic [15:0] W_OCT8  = 16'd32768;
    localparam logic [15:0] W_OCT16 = 16'd19661;
    localparam logic [15:0] W_OCT32 = 16'd9830;
    localparam logic [15:0] W_OCT64 = 16'd3277;

    localparam logic [7:0] TH_SAND  = 8'd28;
    localparam logic [7:0] TH_GRASS = 8'd38;
    localparam logic [7:0] TH_ROCK  = 8'd110;
    localparam logic [7:0] TH_SNOW  = 8'd185;

    localparam logic [2:0] BAND_WATER = 3'd0;
    localparam logic [2:0] BAND_SAND  = 3'd1;
    localparam logic [2:0] BAND_GRASS = 3'd2;
    localparam logic [2:0] BAND_ROCK  = 3'd3;
    localparam logic [2:0] BAND_SNOW  = 3'd4;

    // Item traveling along the chain of cells
    typedef struct packed {
        logic        valid;
        logic [7:0]  px;
        logic [7:0]  py;
        logic [31:0] seed;
        logic [16:0] n4;
        logic [16:0] n8;
        logic [16:0] n16;
        logic [16:0] n32;
        logic [16:0] n64;
    } tvnh_item_t;

endpackage

### sv/tiling_value_noise_heightmap.sv
// Top level of the tiling value-noise heightmap generator.
// Depends on tvnh_pkg, tvnh_octave_cell and tvnh_combine.
//
// Takes one pixel coordinate per clock (busy is always low) and returns its
// height byte and band with a one-cycle done strobe: five
// octave cells of eight stages each in a chain, then four combine stages.
// The receiver cannot stall, so every accepted item comes out exactly once.
// Write planet_index only while no item is in flight.
module tiling_value_noise_heightmap #(
    parameter int TILE_SIZE = tvnh_pkg::TILE_SIZE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  pixel_x,
    input  logic [7:0]  pixel_y,
    input  logic        cfg_we,
    input  logic [30:0] cfg_wdata,
    output logic        done,
    output logic [7:0]  height,
    output logic [2:0]  band
);
    localparam int PERIODS [tvnh_pkg::NUM_OCT] = '{4, 8, 16, 32, 64};

    logic [31:0] seed_reg;
    tvnh_pkg::tvnh_item_t chain [tvnh_pkg::NUM_OCT + 1];

    // hold the seed derived from the planet index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (cfg_we)
        begin
            seed_reg <= 32'(cfg_wdata) * tvnh_pkg::SEED_MULT;
        end
    end

    assign busy = 1'b0;

    always_comb
    begin
        chain[0]       = '0;
        chain[0].valid = start;
        chain[0].px    = pixel_x;
        chain[0].py    = pixel_y;
        chain[0].seed  = seed_reg;
    end

    for (genvar g = 0; g < tvnh_pkg::NUM_OCT; g++)
    begin : g_cell
        tvnh_octave_cell #(
            .TILE_SIZE(TILE_SIZE),
            .PERIOD   (PERIODS[g]),
            .SLOT     (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .item_in (chain[g]),
            .item_out(chain[g+1])
        );
    end

    tvnh_combine u_combine (
        .clk    (clk),
        .rst_n  (rst_n),
        .item_in(chain[tvnh_pkg::NUM_OCT]),
        .done   (done),
        .height (height),
        .band   (band)
    );

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(chain[tvnh_pkg::NUM_OCT].valid, 4))
        else $error("done without item leaving octave chain");
    a_band_snow: assert property (@(posedge clk) disable iff (!rst_n)
        done && band == tvnh_pkg::BAND_SNOW |-> height >= tvnh_pkg::TH_SNOW)
        else $error("snow band below threshold");
    a_band_water: assert property (@(posedge clk) disable iff (!rst_n)
        done && band == tvnh_pkg::BAND_WATER |-> height < tvnh_pkg::TH_SAND)
        else $error("water band above threshold");
`endif
endmodule

### sv/tvnh_octave_cell.sv
// One octave cell: computes the value noise of one period for the item
// passing by and hands the item on. Depends on tvnh_pkg.
module tvnh_octave_cell #(
    parameter int TILE_SIZE = tvnh_pkg::TILE_SIZE_DEF,
    parameter int PERIOD    = 4,
    parameter int SLOT      = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tvnh_pkg::tvnh_item_t item_in,
    output tvnh_pkg::tvnh_item_t item_out
);
    localparam int TB = $clog2(TILE_SIZE);
    localparam int PB = $clog2(PERIOD);
    localparam int SB = 8 + PB;
    localparam int DEPTH = 8;

    // delayed copy of the item while the octave is worked out
    tvnh_pkg::tvnh_item_t dly_reg [DEPTH];
    logic [DEPTH-1:0] vld_reg;

    // stage 0: cell coordinates, fraction and corner hash inputs
    logic [SB-1:0] sx, sy;
    logic [31:0]  cx, cy;
    logic [16:0]  fx0, fy0;
    logic [PB-1:0] xa, xb, ya, yb;

    always_comb
    begin
        sx  = SB'(item_in.px) * SB'(PERIOD);
        sy  = SB'(item_in.py) * SB'(PERIOD);
        cx  = 32'(sx >> TB);
        cy  = 32'(sy >> TB);
        fx0 = 17'((34'(sx & SB'(TILE_SIZE - 1)) << 16) >> TB);
        fy0 = 17'((34'(sy & SB'(TILE_SIZE - 1)) << 16) >> TB);
        xa  = cx[PB-1:0];
        xb  = PB'(cx + 32'd1);
        ya  = cy[PB-1:0];
        yb  = PB'(cy + 32'd1);
    end

    logic [31:0] hx_a, hx_b, hy_a, hy_b, hs;
    always_comb
    begin
        hx_a = 32'(xa) * tvnh_pkg::HASH_X;
        hx_b = 32'(xb) * tvnh_pkg::HASH_X;
        hy_a = 32'(ya) * tvnh_pkg::HASH_Y;
        hy_b = 32'(yb) * tvnh_pkg::HASH_Y;
        hs   = item_in.seed * tvnh_pkg::HASH_S;
    end

    // stage 1 registers
    logic [31:0] hxa_reg, hxb_reg, hya_reg, hyb_reg, hs_reg;
    logic [16:0] fx1_reg, fy1_reg;
    // stage 2: pre-hash sums
    logic [31:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic [16:0] fx2_reg, fy2_reg;
    // stage 3: mixing multiply and ease square
    logic [31:0] ma_reg, mb_reg, mc_reg, md_reg;
    logic [16:0] fx3_reg, fy3_reg;
    logic [33:0] fxx_reg, fyy_reg;
    // stage 4: corner values and ease product
    logic [16:0] va_reg, vb_reg, vc_reg, vd_reg;
    logic [16:0] ex_reg, ey_reg;
    // stage 5: x lerp products
    logic [33:0] pab0_reg, pab1_reg, pcd0_reg, pcd1_reg;
    logic [16:0] ey5_reg;
    // stage 6: x lerp results
    logic [16:0] lab_reg, lcd_reg, ey6_reg;
    // stage 7: y lerp products
    logic [33:0] py0_reg, py1_reg;
    // stage 8: noise value
    logic [16:0] n_reg;

    function automatic logic [31:0] xsh(input logic [31:0] h);
        return h ^ (h >> 13);
    endfunction

    // corner value: (h & 0xFFFF) * 65536 / 65535 = v + (v == 65535)
    function automatic logic [16:0] cval(input logic [31:0] m);
        logic [15:0] v;
        v = m[15:0];
        return (v == 16'hFFFF) ? 17'h10000 : 17'(v);
    endfunction

    logic [17:0] sx_lin, sy_lin;
    logic [33:0] f2x, f2y;
    always_comb
    begin
        f2x    = fxx_reg >> 16;
        f2y    = fyy_reg >> 16;
        sx_lin = 18'(3 * 65536) - 18'({fx3_reg, 1'b0});
        sy_lin = 18'(3 * 65536) - 18'({fy3_reg, 1'b0});
    end

    always_ff @(posedge clk)
    begin
        hxa_reg <= hx_a;
        hxb_reg <= hx_b;
        hya_reg <= hy_a;
        hyb_reg <= hy_b;
        hs_reg  <= hs;
        fx1_reg <= fx0;
        fy1_reg <= fy0;

        pa_reg  <= xsh(hxa_reg + hya_reg + hs_reg);
        pb_reg  <= xsh(hxb_reg + hya_reg + hs_reg);
        pc_reg  <= xsh(hxa_reg + hyb_reg + hs_reg);
        pd_reg  <= xsh(hxb_reg + hyb_reg + hs_reg);
        fx2_reg <= fx1_reg;
        fy2_reg <= fy1_reg;

        ma_reg  <= pa_reg * tvnh_pkg::HASH_MIX;
        mb_reg  <= pb_reg * tvnh_pkg::HASH_MIX;
        mc_reg  <= pc_reg * tvnh_pkg::HASH_MIX;
        md_reg  <= pd_reg * tvnh_pkg::HASH_MIX;
        fxx_reg <= 34'(fx2_reg) * 34'(fx2_reg);
        fyy_reg <= 34'(fy2_reg) * 34'(fy2_reg);
        fx3_reg <= fx2_reg;
        fy3_reg <= fy2_reg;

        va_reg  <= cval(ma_reg);
        vb_reg  <= cval(mb_reg);
        vc_reg  <= cval(mc_reg);
        vd_reg  <= cval(md_reg);
        ex_reg  <= 17'((f2x[17:0] * 36'(sx_lin)) >> 16);
        ey_reg  <= 17'((f2y[17:0] * 36'(sy_lin)) >> 16);

        pab0_reg <= 34'(va_reg) * 34'(tvnh_pkg::ONE_Q16 - 18'(ex_reg));
        pab1_reg <= 34'(vb_reg) * 34'(ex_reg);
        pcd0_reg <= 34'(vc_reg) * 34'(tvnh_pkg::ONE_Q16 - 18'(ex_reg));
        pcd1_reg <= 34'(vd_reg) * 34'(ex_reg);
        ey5_reg  <= ey_reg;

        lab_reg <= 17'((35'(pab0_reg) + 35'(pab1_reg)) >> 16);
        lcd_reg <= 17'((35'(pcd0_reg) + 35'(pcd1_reg)) >> 16);
        ey6_reg <= ey5_reg;

        py0_reg <= 34'(lab_reg) * 34'(tvnh_pkg::ONE_Q16 - 18'(ey6_reg));
        py1_reg <= 34'(lcd_reg) * 34'(ey6_reg);

        n_reg <= 17'((35'(py0_reg) + 35'(py1_reg)) >> 16);
    end

    // advance the item alongside the octave datapath
    always_ff @(posedge clk)
    begin
        dly_reg[0] <= item_in;
        for (int i = 1; i < DEPTH; i++)
        begin
            dly_reg[i] <= dly_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], item_in.valid};
        end
    end

    // drop the result into this octave's slot
    always_comb
    begin
        item_out       = dly_reg[DEPTH-1];
        item_out.valid = vld_reg[DEPTH-1];
        unique case (SLOT)
            0:       item_out.n4  = n_reg;
            1:       item_out.n8  = n_reg;
            2:       item_out.n16 = n_reg;
            3:       item_out.n32 = n_reg;
            default: item_out.n64 = n_reg;
        endcase
    end
endmodule

### sv/tvnh_combine.sv
// Combine stage: weights the five octaves, squares, scales, clamps and bands.
// Depends on tvnh_pkg.
module tvnh_combine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tvnh_pkg::tvnh_item_t item_in,
    output logic                 done,
    output logic [7:0]           height,
    output logic [2:0]           band
);
    logic [2:0]  vld_reg;
    logic [16:0] det_reg, n4_reg;
    logic [16:0] e_reg;
    logic [33:0] e2_reg;
    logic [7:0]  h_reg;
    logic [2:0]  band_reg;
    logic        done_reg;

    logic [34:0] det_sum;
    logic [34:0] e_sum;
    logic [25:0] h_full;
    logic [7:0]  h_sat;

    always_comb
    begin
        det_sum = 35'(33'(item_in.n8) * 33'(tvnh_pkg::W_OCT8))
                + 35'(33'(item_in.n16) * 33'(tvnh_pkg::W_OCT16))
                + 35'(33'(item_in.n32) * 33'(tvnh_pkg::W_OCT32))
                + 35'(33'(item_in.n64) * 33'(tvnh_pkg::W_OCT64));
        e_sum   = 35'(33'(n4_reg) * 33'(tvnh_pkg::W_CONT))
                + 35'(33'(det_reg) * 33'(tvnh_pkg::W_DET));
        h_full  = 26'((e2_reg >> 16) * 34'd255) >> 16;
        h_sat   = (h_full > 26'd255) ? 8'd255 : h_full[7:0];
    end

    // hold the octave sum, then elevation, then square, then height and band
    always_ff @(posedge clk)
    begin
        det_reg <= 17'(det_sum >> 16);
        n4_reg  <= item_in.n4;
        e_reg   <= 17'(e_sum >> 16);
        e2_reg  <= 34'(e_reg) * 34'(e_reg);
        h_reg   <= h_sat;
        priority if (h_sat < tvnh_pkg::TH_SAND)  band_reg <= tvnh_pkg::BAND_WATER;
        else if (h_sat < tvnh_pkg::TH_GRASS)     band_reg <= tvnh_pkg::BAND_SAND;
        else if (h_sat < tvnh_pkg::TH_ROCK)      band_reg <= tvnh_pkg::BAND_GRASS;
        else if (h_sat < tvnh_pkg::TH_SNOW)      band_reg <= tvnh_pkg::BAND_ROCK;
        else                                     band_reg <= tvnh_pkg::BAND_SNOW;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[1:0], item_in.valid};
            done_reg <= vld_reg[2];
        end
    end

    assign done   = done_reg;
    assign height = h_reg;
    assign band   = band_reg;
endmodule

### bench/tiling_value_noise_heightmap_tb.sv
// Testbench for the tiling value-noise heightmap generator.
// Predicts each pixel's height and band in fixed point and checks the results in order.
// Depends on tvnh_pkg and the tiling_value_noise_heightmap RTL.

class heightmap_scoreboard;
    logic [7:0] height_q[$];
    logic [2:0] band_q[$];
    int         errors;

    function new();
        errors = 0;
    endfunction

    // Hash one lattice corner and scale it to 0..65536
    static function longint unsigned corner_level(int unsigned xi, int unsigned yi,
                                                  int unsigned seed);
        int unsigned h;
        h = xi * tvnh_pkg::HASH_X + yi * tvnh_pkg::HASH_Y + seed * tvnh_pkg::HASH_S;
        h = (h ^ (h >> 13)) * tvnh_pkg::HASH_MIX;
        return (longint'(h & 32'hFFFF) << 16) / 65535;
    endfunction

    static function longint unsigned smooth(longint unsigned f);
        longint unsigned f2;
        f2 = (f * f) >> 16;
        return (f2 * (3 * 65536 - 2 * f)) >> 16;
    endfunction

    static function longint unsigned blend(longint unsigned a, longint unsigned b,
                                           longint unsigned t);
        return (a * (65536 - t) + b * t) >> 16;
    endfunction

    static function longint unsigned octave_level(int unsigned px, int unsigned py,
                                                  int unsigned period, int unsigned seed);
        longint unsigned sx, sy, fx, fy, a, b, c, d;
        int unsigned mask, x0, y0;
        sx = longint'(px) * period;
        sy = longint'(py) * period;
        mask = period - 1;
        x0 = 32'(sx / 256);
        y0 = 32'(sy / 256);
        fx = smooth(((sx % 256) << 16) / 256);
        fy = smooth(((sy % 256) << 16) / 256);
        a = corner_level(x0 & mask, y0 & mask, seed);
        b = corner_level((x0 + 1) & mask, y0 & mask, seed);
        c = corner_level(x0 & mask, (y0 + 1) & mask, seed);
        d = corner_level((x0 + 1) & mask, (y0 + 1) & mask, seed);
        return blend(blend(a, b, fx), blend(c, d, fx), fy);
    endfunction

    // Note an accepted pixel and queue its height and band
    function void note_pixel(logic [7:0] px, logic [7:0] py, logic [30:0] planet);
        int unsigned seed;
        longint unsigned cont, det, e, h;
        logic [2:0] bnd;
        seed = int'(planet) * tvnh_pkg::SEED_MULT;
        cont = octave_level(px, py, 4, seed);
        det = (32768 * octave_level(px, py, 8, seed) + 19661 * octave_level(px, py, 16, seed)
             + 9830 * octave_level(px, py, 32, seed)
             + 3277 * octave_level(px, py, 64, seed)) >> 16;
        e = (39322 * cont + 26214 * det) >> 16;
        h = (((e * e) >> 16) * 255) >> 16;
        if (h > 255) h = 255;
        if (h < tvnh_pkg::TH_SAND) bnd = tvnh_pkg::BAND_WATER;
        else if (h < tvnh_pkg::TH_GRASS) bnd = tvnh_pkg::BAND_SAND;
        else if (h < tvnh_pkg::TH_ROCK) bnd = tvnh_pkg::BAND_GRASS;
        else if (h < tvnh_pkg::TH_SNOW) bnd = tvnh_pkg::BAND_ROCK;
        else bnd = tvnh_pkg::BAND_SNOW;
        height_q.push_back(h[7:0]);
        band_q.push_back(bnd);
    endfunction

    // Compare one result with the oldest expectation
    function void check_pixel(logic [7:0] h, logic [2:0] b);
        logic [7:0] eh;
        logic [2:0] eb;
        if (height_q.size() == 0)
        begin
            $display("%0t: unexpected result height %0d band %0d", $time, h, b);
            errors++;
            return;
        end
        eh = height_q.pop_front();
        eb = band_q.pop_front();
        if (h !== eh)
        begin
            $display("%0t: height expected %0d actual %0d", $time, eh, h);
            errors++;
        end
        if (b !== eb)
        begin
            $display("%0t: band expected %0d actual %0d", $time, eb, b);
            errors++;
        end
    endfunction
endclass

module tiling_value_noise_heightmap_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 50;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic        cfg_we;
    logic [30:0] cfg_wdata;
    logic        done;
    logic [7:0]  height;
    logic [2:0]  band;

    logic [30:0] planet;
    heightmap_scoreboard sb;
    int          stall_phase;

    tiling_value_noise_heightmap i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .height    (height),
        .band      (band)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Check results as they leave the block
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_pixel(height, band);
    end

    // Send one pixel and hold start until it is taken
    task automatic send_pixel(logic [7:0] px, logic [7:0] py);
        start <= 1'b1;
        pixel_x <= px;
        pixel_y <= py;
        do @(posedge clk); while (busy);
        sb.note_pixel(px, py, planet);
    endtask

    task automatic pause(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Drain the pipeline, then write the register
    task automatic write_planet(logic [30:0] value);
        pause(1);
        while (sb.height_q.size() != 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        planet = value;
        @(posedge clk);
    endtask

    // Random bursts with random gaps; some stretches run without gaps
    task automatic random_pixels(int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 40);
            for (int i = 0; i < burst && sent < count; i++)
            begin
                send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                sent++;
            end
            stall_phase = $urandom_range(0, 3);
            if (stall_phase != 0)
                pause($urandom_range(1, 12));
        end
    endtask

    initial
    begin
        logic [7:0] edges[4];
        sb = new();
        edges = '{8'd0, 8'd1, 8'd128, 8'd255};
        rst_n = 1'b0;
        start = 1'b0;
        pixel_x = 8'd0;
        pixel_y = 8'd0;
        cfg_we = 1'b0;
        cfg_wdata = 31'd0;
        planet = 31'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corners, edges and inner points of the tile at the reset world
        foreach (edges[i])
            foreach (edges[j])
                send_pixel(edges[i], edges[j]);
        send_pixel(8'd63, 8'd64);
        send_pixel(8'd31, 8'd200);
        pause(1);

        // Wait for everything, then carry on with a fresh world
        while (sb.height_q.size() != 0) @(posedge clk);

        write_planet(31'h7FFFFFFF);
        send_pixel(8'd0, 8'd0);
        send_pixel(8'd255, 8'd255);
        random_pixels(250);
        write_planet(31'd1);
        random_pixels(250);
        write_planet(31'h2AAAAAAA);
        random_pixels(200);
        write_planet(31'($urandom()));
        random_pixels(200);
        write_planet(31'h55555555);
        random_pixels(200);
        write_planet(31'd0);
        random_pixels(50);
        pause(1);

        while (sb.height_q.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (sb.errors == 0)
            $display("tiling_value_noise_heightmap_tb OK");
        else
            $display("tiling_value_noise_heightmap_tb NOT OK");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("tiling_value_noise_heightmap_tb NOT OK");
        $finish;
    end
endmodule
